@@ src/psimp_pkg.sv @@
// shared constants and types of the polyline simplifier
package psimp_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int COORD_W     = 16;
   localparam int TOL_W       = 16;
   localparam int MIN_SPLIT   = 3;
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W      = COORD_W + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int DEV_W       = (2 * SQ_W > 2 * TOL_W + SQ_W) ? 2 * SQ_W : 2 * TOL_W + SQ_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = 3;
   localparam int REG_IDX_W   = ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_METRIC    = REG_IDX_W'(1);

   localparam logic METRIC_LINE    = 1'b0;
   localparam logic METRIC_SEGMENT = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
      logic                      keep;
      logic [IDX_W-1:0]          idx;
      logic [CNT_W-1:0]          count;
      logic                      ovf;
   } entry_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] depth;
   } status_type;

endpackage

@@ src/psimp_front.sv @@
// input side: counts points of the path, flags drops, builds queue entries
module psimp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [psimp_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [psimp_pkg::COORD_W-1:0] req_point_y,
   input  logic                               req_last_point,
   input  logic                               q_full,
   output logic                               q_push,
   output psimp_pkg::entry_type               q_entry
);
   import psimp_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             room;
   logic [CNT_W-1:0] count_next;
   logic             drop_next;

   assign req_stall  = q_full;
   assign q_push     = req_valid && !q_full;
   assign room       = count_ff < CNT_W'(MAX_POINTS);
   assign count_next = room ? count_ff + CNT_W'(1) : count_ff;
   assign drop_next  = drop_ff || !room;

   always_comb begin
      q_entry.x     = req_point_x;
      q_entry.y     = req_point_y;
      q_entry.last  = req_last_point;
      q_entry.keep  = room;
      q_entry.idx   = count_ff[IDX_W-1:0];
      q_entry.count = count_next;
      q_entry.ovf   = drop_next;
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (q_push) begin
         if (req_last_point) begin
            count_in = '0;
            drop_in  = 1'b0;
         end else begin
            count_in = count_next;
            drop_in  = drop_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

@@ src/psimp_queue.sv @@
// short fifo of classified points between front and engine
module psimp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psimp_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output psimp_pkg::entry_type head_entry
);
   import psimp_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_entry = slot_ff[rptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QPTR_W'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

@@ src/psimp_engine.sv @@
// back end: point store, segment stack, deviation datapath and result emission
module psimp_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [psimp_pkg::TOL_W-1:0]          tolerance,
   input  logic                                 metric_mode,
   input  logic                                 head_valid,
   input  psimp_pkg::entry_type                 head_entry,
   output logic                                 pop,
   output psimp_pkg::status_type                status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [psimp_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [psimp_pkg::COORD_W-1:0] rsp_out_y,
   output logic                                 rsp_last_out,
   output logic                                 rsp_overflow
);
   import psimp_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_POP   = 4'd1;
   localparam logic [3:0] ST_SRD   = 4'd2;
   localparam logic [3:0] ST_LEN1  = 4'd3;
   localparam logic [3:0] ST_LEN2  = 4'd4;
   localparam logic [3:0] ST_LEN3  = 4'd5;
   localparam logic [3:0] ST_THR   = 4'd6;
   localparam logic [3:0] ST_PRD   = 4'd7;
   localparam logic [3:0] ST_PMUL  = 4'd8;
   localparam logic [3:0] ST_PSUM  = 4'd9;
   localparam logic [3:0] ST_PDEV  = 4'd10;
   localparam logic [3:0] ST_PCMP  = 4'd11;
   localparam logic [3:0] ST_DEC   = 4'd12;
   localparam logic [3:0] ST_PUSHR = 4'd13;
   localparam logic [3:0] ST_PUSHL = 4'd14;
   localparam logic [3:0] ST_EMIT  = 4'd15;

   // memories
   logic [2*COORD_W-1:0] pts_mem [MAX_POINTS];
   logic [2*IDX_W-1:0]   stk_mem [MAX_POINTS];
   logic [2*COORD_W-1:0] rda_ff, rdb_ff;
   logic [2*IDX_W-1:0]   stk_rd_ff;
   logic                 pt_we;
   logic [IDX_W-1:0]     pt_waddr, rda_addr, rdb_addr, stk_waddr, stk_raddr;
   logic                 stk_we;
   logic [2*IDX_W-1:0]   stk_wdata;

   // control
   logic [3:0]            state_ff, state_in;
   logic                  eout_ff, eout_in;
   logic [CNT_W-1:0]      count_ff, count_in, depth_ff, depth_in, eidx_ff, eidx_in;
   logic                  ovf_ff, ovf_in;
   logic [MAX_POINTS-1:0] keep_ff, keep_in;
   logic [IDX_W-1:0]      s_ff, s_in, e_ff, e_in, i_ff, i_in, best_ff, best_in;
   logic [DEV_W-1:0]      max_ff, max_in;

   // segment datapath
   logic signed [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [DIFF_W-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic signed [SQ_W-1:0]    ax2_ff, ay2_ff;
   logic [SQ_W-1:0]           len2_ff, den;
   logic [2*TOL_W-1:0]        tsq_ff;
   logic [DEV_W-1:0]          thr_ff;

   // point datapath
   logic signed [COORD_W-1:0] px, py;
   logic signed [DIFF_W-1:0]  bx, by, cx, cy;
   logic signed [SQ_W-1:0]    bxbx_ff, byby_ff, cxcx_ff, cycy_ff;
   logic signed [SQ_W-1:0]    axby_ff, aybx_ff, axbx_ff, ayby_ff, axcx_ff, aycy_ff;
   logic signed [SQ_W-1:0]    crs, dotb, dotc;
   logic [SQ_W-1:0]           b2_ff, c2_ff, crm_ff, op1, op2;
   logic                      dotb_le_ff, dotc_ge_ff;
   logic [DEV_W-1:0]          dev_ff;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in, rsp_load;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                      rsp_last_ff, rsp_ovf_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = rsp_x_ff;
   assign rsp_out_y    = rsp_y_ff;
   assign rsp_last_out = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

   assign status.busy  = (state_ff != ST_IDLE) || eout_ff;
   assign status.depth = depth_ff;

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pts_mem[pt_waddr] <= {head_entry.x, head_entry.y};
      end
      rda_ff <= pts_mem[rda_addr];
      rdb_ff <= pts_mem[rdb_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   assign pt_waddr  = head_entry.idx;
   assign stk_raddr = IDX_W'(depth_ff - CNT_W'(1));
   assign rdb_addr  = stk_rd_ff[IDX_W-1:0];
   assign rda_addr  = (state_ff == ST_SRD && !eout_ff) ? stk_rd_ff[2*IDX_W-1:IDX_W] :
                      (state_ff == ST_EMIT || eout_ff) ? eidx_ff[IDX_W-1:0] : i_ff;

   // segment chord and threshold
   assign px = rda_ff[2*COORD_W-1:COORD_W];
   assign py = rda_ff[COORD_W-1:0];
   assign den = (len2_ff == '0) ? SQ_W'(1) : len2_ff;

   always_ff @(posedge clock) begin
      ax2_ff  <= ax_ff * ax_ff;
      ay2_ff  <= ay_ff * ay_ff;
      len2_ff <= $unsigned(ax2_ff + ay2_ff);
      tsq_ff  <= tolerance * tolerance;
      thr_ff  <= DEV_W'(tsq_ff * den);
   end

   // per point deviation, one stage per cycle
   assign bx = {px[COORD_W-1], px} - {sx_ff[COORD_W-1], sx_ff};
   assign by = {py[COORD_W-1], py} - {sy_ff[COORD_W-1], sy_ff};
   assign cx = {px[COORD_W-1], px} - {ex_ff[COORD_W-1], ex_ff};
   assign cy = {py[COORD_W-1], py} - {ey_ff[COORD_W-1], ey_ff};
   assign crs  = axby_ff - aybx_ff;
   assign dotb = axbx_ff + ayby_ff;
   assign dotc = axcx_ff + aycy_ff;

   always_comb begin
      if (len2_ff == '0) begin
         op1 = b2_ff;
         op2 = SQ_W'(1);
      end else if (metric_mode == METRIC_LINE) begin
         op1 = crm_ff;
         op2 = crm_ff;
      end else if (dotb_le_ff) begin
         op1 = b2_ff;
         op2 = len2_ff;
      end else if (dotc_ge_ff) begin
         op1 = c2_ff;
         op2 = len2_ff;
      end else begin
         op1 = crm_ff;
         op2 = crm_ff;
      end
   end

   always_ff @(posedge clock) begin
      bxbx_ff    <= bx * bx;
      byby_ff    <= by * by;
      cxcx_ff    <= cx * cx;
      cycy_ff    <= cy * cy;
      axby_ff    <= ax_ff * by;
      aybx_ff    <= ay_ff * bx;
      axbx_ff    <= ax_ff * bx;
      ayby_ff    <= ay_ff * by;
      axcx_ff    <= ax_ff * cx;
      aycy_ff    <= ay_ff * cy;
      b2_ff      <= $unsigned(bxbx_ff + byby_ff);
      c2_ff      <= $unsigned(cxcx_ff + cycy_ff);
      crm_ff     <= crs[SQ_W-1] ? $unsigned(-crs) : $unsigned(crs);
      dotb_le_ff <= dotb[SQ_W-1] || (dotb == '0);
      dotc_ge_ff <= !dotc[SQ_W-1];
      dev_ff     <= DEV_W'(op1 * op2);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      eout_in   = eout_ff;
      count_in  = count_ff;
      depth_in  = depth_ff;
      eidx_in   = eidx_ff;
      ovf_in    = ovf_ff;
      keep_in   = keep_ff;
      s_in      = s_ff;
      e_in      = e_ff;
      i_in      = i_ff;
      best_in   = best_ff;
      max_in    = max_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      ex_in     = ex_ff;
      ey_in     = ey_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      pop       = 1'b0;
      pt_we     = 1'b0;
      stk_we    = 1'b0;
      stk_waddr = depth_ff[IDX_W-1:0];
      stk_wdata = {best_ff, e_ff};
      rsp_load  = 1'b0;
      if (eout_ff) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_load = 1'b1;
            eidx_in  = eidx_ff + CNT_W'(1);
            eout_in  = 1'b0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  pop   = 1'b1;
                  pt_we = head_entry.keep;
                  if (head_entry.last) begin
                     count_in = head_entry.count;
                     ovf_in   = head_entry.ovf;
                     keep_in[0] = 1'b1;
                     keep_in[IDX_W'(head_entry.count - CNT_W'(1))] = 1'b1;
                     eidx_in  = '0;
                     if (head_entry.count >= CNT_W'(MIN_SPLIT)) begin
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = {IDX_W'(0), IDX_W'(head_entry.count - CNT_W'(1))};
                        depth_in  = CNT_W'(1);
                        state_in  = ST_POP;
                     end else begin
                        depth_in = '0;
                        state_in = ST_EMIT;
                     end
                  end
               end
            end
            ST_POP: begin
               depth_in = depth_ff - CNT_W'(1);
               state_in = ST_SRD;
            end
            ST_SRD: begin
               s_in     = stk_rd_ff[2*IDX_W-1:IDX_W];
               e_in     = stk_rd_ff[IDX_W-1:0];
               state_in = ST_LEN1;
            end
            ST_LEN1: begin
               sx_in    = rda_ff[2*COORD_W-1:COORD_W];
               sy_in    = rda_ff[COORD_W-1:0];
               ex_in    = rdb_ff[2*COORD_W-1:COORD_W];
               ey_in    = rdb_ff[COORD_W-1:0];
               ax_in    = {rdb_ff[2*COORD_W-1], rdb_ff[2*COORD_W-1:COORD_W]}
                        - {rda_ff[2*COORD_W-1], rda_ff[2*COORD_W-1:COORD_W]};
               ay_in    = {rdb_ff[COORD_W-1], rdb_ff[COORD_W-1:0]}
                        - {rda_ff[COORD_W-1], rda_ff[COORD_W-1:0]};
               state_in = ST_LEN2;
            end
            ST_LEN2: state_in = ST_LEN3;
            ST_LEN3: state_in = ST_THR;
            ST_THR: begin
               max_in   = '0;
               best_in  = '0;
               i_in     = s_ff + IDX_W'(1);
               state_in = ST_PRD;
            end
            ST_PRD:  state_in = ST_PMUL;
            ST_PMUL: state_in = ST_PSUM;
            ST_PSUM: state_in = ST_PDEV;
            ST_PDEV: state_in = ST_PCMP;
            ST_PCMP: begin
               if (dev_ff > max_ff) begin
                  max_in  = dev_ff;
                  best_in = i_ff;
               end
               i_in     = i_ff + IDX_W'(1);
               state_in = (i_ff + IDX_W'(1) == e_ff) ? ST_DEC : ST_PRD;
            end
            ST_DEC: begin
               if (best_ff == '0 || max_ff < thr_ff) begin
                  state_in = (depth_ff != '0) ? ST_POP : ST_EMIT;
               end else begin
                  keep_in[best_ff] = 1'b1;
                  state_in = ST_PUSHR;
               end
            end
            ST_PUSHR: begin
               if (e_ff - best_ff >= IDX_W'(MIN_SPLIT - 1) &&
                   depth_ff < CNT_W'(MAX_POINTS)) begin
                  stk_we    = 1'b1;
                  stk_wdata = {best_ff, e_ff};
                  depth_in  = depth_ff + CNT_W'(1);
               end
               state_in = ST_PUSHL;
            end
            ST_PUSHL: begin
               if (best_ff - s_ff >= IDX_W'(MIN_SPLIT - 1) &&
                   depth_ff < CNT_W'(MAX_POINTS)) begin
                  stk_we    = 1'b1;
                  stk_wdata = {s_ff, best_ff};
                  depth_in  = depth_ff + CNT_W'(1);
               end
               state_in = (depth_in != '0) ? ST_POP : ST_EMIT;
            end
            ST_EMIT: begin
               if (eidx_ff == count_ff) begin
                  keep_in  = '0;
                  state_in = ST_IDLE;
               end else if (!keep_ff[eidx_ff[IDX_W-1:0]]) begin
                  eidx_in = eidx_ff + CNT_W'(1);
               end else begin
                  eout_in = 1'b1;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // rsp_valid is set on each load and held while rsp_stall stays high
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff    <= rda_ff[2*COORD_W-1:COORD_W];
         rsp_y_ff    <= rda_ff[COORD_W-1:0];
         rsp_last_ff <= (eidx_ff == count_ff - CNT_W'(1));
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      e_ff    <= e_in;
      i_ff    <= i_in;
      best_ff <= best_in;
      max_ff  <= max_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      count_ff <= count_in;
      eidx_ff  <= eidx_in;
      ovf_ff   <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eout_ff      <= 1'b0;
         depth_ff     <= '0;
         keep_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eout_ff      <= eout_in;
         depth_ff     <= depth_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/polyline_simplifier_unit.sv @@
// top level of the polyline simplifier: register port, front, queue and engine
//
// Path points enter on the req channel, one transaction per point, the final point
// flagged by req_last_point. While the engine is idle points are taken one per cycle;
// a two-entry queue lets the front keep accepting while the engine finishes a
// previous step, and req_stall rises only when that queue is full. When the last
// point reaches the engine it runs Ramer-Douglas-Peucker with a stack of segments,
// all through one shared deviation datapath and the store's two read ports; paths
// of fewer than three points skip the search. The kept points then leave on the
// rsp channel in path order as the stored points are scanned; rsp_last_out marks
// the final one and rsp_overflow is set on all of them when points past the
// 64-point store were dropped. Registers: tolerance at byte address 0 (reset 1),
// metric_mode at 4 (0 line distance, 1 segment distance); write them only while
// the block is idle.
module polyline_simplifier_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [psimp_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [psimp_pkg::COORD_W-1:0] req_point_y,
   input  logic                                 req_last_point,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [psimp_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [psimp_pkg::COORD_W-1:0] rsp_out_y,
   output logic                                 rsp_last_out,
   output logic                                 rsp_overflow,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [psimp_pkg::ADDR_W-1:0]         paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import psimp_pkg::*;

   // configuration registers
   logic [TOL_W-1:0]     tolerance_ff, tolerance_in;
   logic                 metric_ff, metric_in;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] reg_idx;

   // front to engine
   logic       q_push, q_full, q_pop, q_head_valid;
   entry_type  q_entry, q_head;
   status_type eng_status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = paddr[ADDR_W-1:2];

   always_comb begin
      tolerance_in = tolerance_ff;
      metric_in    = metric_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_TOLERANCE: tolerance_in = pwdata[TOL_W-1:0];
            REG_METRIC:    metric_in    = pwdata[0];
            default:       ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_TOLERANCE: prdata = 32'(tolerance_ff);
         REG_METRIC:    prdata = 32'(metric_ff);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOL_W'(1);
         metric_ff    <= METRIC_LINE;
      end else begin
         tolerance_ff <= tolerance_in;
         metric_ff    <= metric_in;
      end
   end

   // classify and count incoming points
   psimp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   // decouples loading from simplification
   psimp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   // store, segment stack, deviation search and emission
   psimp_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .tolerance    (tolerance_ff),
      .metric_mode  (metric_ff),
      .head_valid   (q_head_valid),
      .head_entry   (q_head),
      .pop          (q_pop),
      .status       (eng_status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_last_out (rsp_last_out),
      .rsp_overflow (rsp_overflow)
   );

   // queue never takes a point it has no slot for
   a_no_queue_overrun: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("point queue overrun");

   // segment stack stays within its memory
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      eng_status.depth <= CNT_W'(MAX_POINTS))
      else $error("segment stack depth out of range");

   // no result shows up while the engine sits idle with nothing pending
   a_result_needs_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(eng_status.busy))
      else $error("result without engine activity");

endmodule
